>>> hw/rtl/mbc1_pkg.sv
// ----------------------------------------------------------------------------
// MBC1 bank mapper package
// Word types, result codes and address map constants shared by the mapper
// core and its checker.
// ----------------------------------------------------------------------------
package mbc1_pkg;

  // Result codes: where a bus access ends up.
  typedef enum logic [2:0] {
    TGT_IGNORE    = 3'd0,
    TGT_ROM_READ  = 3'd1,
    TGT_RAM_READ  = 3'd2,
    TGT_RAM_WRITE = 3'd3,
    TGT_OPEN_BUS  = 3'd4
  } target_e;

  // Access kinds.
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // 8 KiB regions of the CPU address space, selected by address[15:13].
  localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
  localparam logic [2:0] REGION_ROM_BANK   = 3'd1;
  localparam logic [2:0] REGION_RAM_BANK   = 3'd2;
  localparam logic [2:0] REGION_MODE       = 3'd3;
  localparam logic [2:0] REGION_EXT_RAM    = 3'd5;

  localparam logic [15:0] ROM_SWITCH_BASE = 16'h4000;
  localparam logic [15:0] EXT_RAM_BASE    = 16'hA000;
  localparam logic [3:0]  RAM_ENABLE_KEY  = 4'hA;

  // Cartridge types that turn the mapper on, and the battery-backed type.
  localparam logic [7:0] CART_MAP_FIRST = 8'h01;
  localparam logic [7:0] CART_MAP_LAST  = 8'h13;
  localparam logic [7:0] CART_BATTERY   = 8'h03;

  // RAM size codes from the cartridge header.
  localparam logic [2:0] RAM_SIZE_ONE_BANK    = 3'd2;
  localparam logic [2:0] RAM_SIZE_FOUR_BANKS  = 3'd3;
  localparam logic [2:0] RAM_SIZE_SIXTEEN     = 3'd4;
  localparam logic [2:0] RAM_SIZE_EIGHT_BANKS = 3'd5;

  // Configuration register map (word index, byte address is 4 * index).
  localparam logic REG_CART_TYPE     = 1'b0;
  localparam logic REG_RAM_SIZE_CODE = 1'b1;

  localparam int ROM_BANK_BITS = 14;   // 16 KiB ROM banks
  localparam int RAM_BANK_BITS = 13;   // 8 KiB RAM banks

  typedef struct packed {
    logic        mode;
    logic [15:0] address;
    logic [7:0]  write_byte;
  } in_word_t;

  typedef struct packed {
    target_e     target;
    logic [19:0] rom_address;
    logic [14:0] ram_address;
    logic        save_request;
    logic        save_dirty;
  } out_word_t;

endpackage

>>> hw/rtl/mbc1_bank_mapper_core.sv
// ----------------------------------------------------------------------------
// MBC1 bank mapper core
// Maps CPU bus accesses onto cartridge ROM and RAM addresses and tracks the
// bank registers written through the control ranges.
// ----------------------------------------------------------------------------
// Each input word is one CPU bus access and produces exactly one output word,
// in order. Throughput is one access per clock unless the result is stalled:
// an accepted word is held in the input register, then a short decode (region
// compare, bank shift-add) writes the result register and updates the bank
// registers at the same edge, so the next access already sees the new bank
// state. Output valid rises when the decoded word is written into the result
// register. The input register and the result register each hold one word, so
// the block keeps taking input while a finished result waits on a stalled
// consumer; only when both are full and the result is stalled does in_stall_o
// rise. Configuration (cart_type at byte 0x0, ram_size_code at byte 0x4) is to
// be written by the user through the APB-style port only while the block is
// idle; the block itself does not enforce this. Battery save I/O is not
// performed here: save_request pulses where a save would happen and save_dirty
// reports whether battery RAM was written since reset.
module mbc1_bank_mapper_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  mbc1_pkg::in_word_t    in_word_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mbc1_pkg::out_word_t   out_word_o,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0] cart_type_q;
  logic [2:0] ram_size_code_q;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cart_type_q     <= mbc1_pkg::CART_MAP_FIRST;
      ram_size_code_q <= '0;
    end else if (cfg_write) begin
      if (paddr[2] == mbc1_pkg::REG_CART_TYPE) begin
        cart_type_q <= pwdata[7:0];
      end else begin
        ram_size_code_q <= pwdata[2:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == mbc1_pkg::REG_CART_TYPE) begin
      prdata = {24'd0, cart_type_q};
    end else begin
      prdata = {29'd0, ram_size_code_q};
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: input register feeding the result register
  // --------------------------------------------------------------------------
  logic                in_valid_q;
  mbc1_pkg::in_word_t  in_q;
  logic                out_valid_q;
  mbc1_pkg::out_word_t out_q;
  logic                out_free;
  logic                advance;
  logic                in_accept;

  // The result register can take a word when it is empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_accept || (in_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_word_i;
    end
  end

  // --------------------------------------------------------------------------
  // Bank state
  // --------------------------------------------------------------------------
  logic       ram_enable_q,      ram_enable_d;
  logic [4:0] rom_bank_q,        rom_bank_d;
  logic [1:0] ram_bank_select_q, ram_bank_select_d;
  logic       banking_mode_q,    banking_mode_d;
  logic [1:0] active_ram_bank_q, active_ram_bank_d;
  logic       dirty_flag_q,      dirty_flag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_enable_q      <= 1'b0;
      rom_bank_q        <= 5'd1;
      ram_bank_select_q <= 2'd0;
      banking_mode_q    <= 1'b0;
      active_ram_bank_q <= 2'd0;
      dirty_flag_q      <= 1'b0;
    end else if (advance) begin
      ram_enable_q      <= ram_enable_d;
      rom_bank_q        <= rom_bank_d;
      ram_bank_select_q <= ram_bank_select_d;
      banking_mode_q    <= banking_mode_d;
      active_ram_bank_q <= active_ram_bank_d;
      dirty_flag_q      <= dirty_flag_d;
    end
  end

  // --------------------------------------------------------------------------
  // Access decode
  // --------------------------------------------------------------------------
  logic                mapping_on;
  logic                bank_present;
  logic                ram_ok;
  logic [2:0]          region;
  logic [15:0]         rom_offset;
  logic [14:0]         ram_addr;
  mbc1_pkg::out_word_t result;

  assign mapping_on = (cart_type_q >= mbc1_pkg::CART_MAP_FIRST) &&
                      (cart_type_q <= mbc1_pkg::CART_MAP_LAST);
  assign region     = in_q.address[15:13];
  assign rom_offset = in_q.address - mbc1_pkg::ROM_SWITCH_BASE;
  // The external RAM window is 8 KiB aligned, so the offset is the low bits.
  assign ram_addr   = {active_ram_bank_q, in_q.address[mbc1_pkg::RAM_BANK_BITS-1:0]};

  // Provisioning follows the RAM size code currently configured. Codes for
  // eight or sixteen banks cover every bank the 2-bit select can reach.
  always_comb begin
    unique case (ram_size_code_q)
      mbc1_pkg::RAM_SIZE_ONE_BANK:    bank_present = (active_ram_bank_q == 2'd0);
      mbc1_pkg::RAM_SIZE_FOUR_BANKS,
      mbc1_pkg::RAM_SIZE_SIXTEEN,
      mbc1_pkg::RAM_SIZE_EIGHT_BANKS: bank_present = 1'b1;
      default:                        bank_present = 1'b0;
    endcase
  end

  assign ram_ok = ram_enable_q && bank_present;

  always_comb begin
    ram_enable_d        = ram_enable_q;
    rom_bank_d          = rom_bank_q;
    ram_bank_select_d   = ram_bank_select_q;
    banking_mode_d      = banking_mode_q;
    active_ram_bank_d   = active_ram_bank_q;
    dirty_flag_d        = dirty_flag_q;

    result              = '0;
    result.target       = mbc1_pkg::TGT_IGNORE;

    if (in_q.mode == mbc1_pkg::ACC_READ) begin
      if ((in_q.address < mbc1_pkg::ROM_SWITCH_BASE) || !mapping_on) begin
        // Fixed bank, or mapping off: the address is used as is.
        result.target      = mbc1_pkg::TGT_ROM_READ;
        result.rom_address = {4'd0, in_q.address};
      end else if (region == mbc1_pkg::REGION_EXT_RAM) begin
        if (ram_ok) begin
          result.target      = mbc1_pkg::TGT_RAM_READ;
          result.ram_address = ram_addr;
        end else begin
          result.target = mbc1_pkg::TGT_OPEN_BUS;
        end
      end else begin
        // Everything else above 0x4000 reads the switched ROM bank.
        result.target      = mbc1_pkg::TGT_ROM_READ;
        result.rom_address = {1'b0, rom_bank_q, {mbc1_pkg::ROM_BANK_BITS{1'b0}}} +
                             {4'd0, rom_offset};
      end
    end else if (mapping_on) begin
      unique case (region)
        mbc1_pkg::REGION_RAM_ENABLE: begin
          ram_enable_d = (in_q.write_byte[3:0] == mbc1_pkg::RAM_ENABLE_KEY);
        end
        mbc1_pkg::REGION_ROM_BANK: begin
          // A bank number of zero is promoted to one before masking.
          rom_bank_d = (in_q.write_byte == 8'd0) ? 5'd1 : in_q.write_byte[4:0];
        end
        mbc1_pkg::REGION_RAM_BANK: begin
          ram_bank_select_d = in_q.write_byte[1:0];
          if (banking_mode_q) begin
            active_ram_bank_d   = in_q.write_byte[1:0];
            result.save_request = dirty_flag_q;
          end
        end
        mbc1_pkg::REGION_MODE: begin
          banking_mode_d = in_q.write_byte[0];
          if (in_q.write_byte[0]) begin
            active_ram_bank_d   = ram_bank_select_q;
            result.save_request = dirty_flag_q;
          end
        end
        mbc1_pkg::REGION_EXT_RAM: begin
          if (ram_ok) begin
            result.target      = mbc1_pkg::TGT_RAM_WRITE;
            result.ram_address = ram_addr;
            if (cart_type_q == mbc1_pkg::CART_BATTERY) begin
              dirty_flag_d = 1'b1;
            end
          end
        end
        default: begin
          // Writes to video RAM, work RAM and the top of the map are dropped.
        end
      endcase
    end

    result.save_dirty = dirty_flag_d;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

>>> hw/rtl/mbc1_checker.sv
// ----------------------------------------------------------------------------
// MBC1 bank mapper checker
// Port-level assertions on the mapper core, attached by bind.
// ----------------------------------------------------------------------------
module mbc1_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  mbc1_pkg::out_word_t out_word_o
);

  logic dirty_seen_q;
  logic out_accept;

  assign out_accept = out_valid_o && !out_stall_i;

  // Remembers that a delivered word already reported battery RAM as dirty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_seen_q <= 1'b0;
    end else if (out_accept && out_word_o.save_dirty) begin
      dirty_seen_q <= 1'b1;
    end
  end

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // The dirty flag is only ever set, never cleared.
  a_dirty_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dirty_seen_q |-> out_word_o.save_dirty)
    else $error("dirty flag cleared after being reported");

  // A save is only requested when battery RAM is dirty.
  a_save_needs_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.save_request |-> out_word_o.save_dirty)
    else $error("save request without dirty battery RAM");

  // Only the address that belongs to the target is nonzero.
  a_address_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_word_o.rom_address == '0 || out_word_o.target == mbc1_pkg::TGT_ROM_READ) &&
      (out_word_o.ram_address == '0 || out_word_o.target == mbc1_pkg::TGT_RAM_READ ||
       out_word_o.target == mbc1_pkg::TGT_RAM_WRITE))
    else $error("address given for a target that does not use it");

endmodule

bind mbc1_bank_mapper_core mbc1_checker u_mbc1_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
